@@ rtl/bba_pkg.sv @@
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types, codes and helpers for the buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

  // Field widths of the transfer payloads
  localparam int FUNC_W = 2;
  localparam int REQ_W  = 11;
  localparam int OFF_W  = 10;
  localparam int ST_W   = 2;
  localparam int BSZ_W  = 11;
  // Rounded request: up to 2048
  localparam int WANT_W = 12;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_NOSPACE  = 2'd1;
  localparam logic [ST_W-1:0] ST_NOTALLOC = 2'd2;

  // Datapath commands
  typedef enum logic [3:0] {
    OP_NOP,
    OP_CLR_INIT,
    OP_CLR,
    OP_LOAD,
    OP_ROOT,
    OP_DESC,
    OP_MARK,
    OP_CLIMB_UP,
    OP_FOUND,
    OP_UP_RD,
    OP_UP_WR,
    OP_FAIL_SPACE,
    OP_FAIL_ALLOC,
    OP_PUBLISH
  } dp_op_t;

  // Datapath status seen by the controller
  typedef struct packed {
    logic              clr_last;
    logic              off_bad;
    logic              root_short;
    logic              sz_gt_want;
    logic              half_gt_want;
    logic              rd_zero;
    logic              at_root;
    logic [FUNC_W-1:0] func;
    logic [FUNC_W-1:0] new_func;
  } dp_status_t;

  // Round up to a power of two; zero becomes one
  function automatic logic [WANT_W-1:0] round_pow2(input logic [REQ_W-1:0] v);
    logic [WANT_W-1:0] p;
    logic              found;
    p     = '0;
    found = 1'b0;
    for (int k = 0; k < WANT_W; k++) begin
      if (!found && ((WANT_W'(1) << k) >= WANT_W'(v))) begin
        p     = WANT_W'(1) << k;
        found = 1'b1;
      end
    end
    return p;
  endfunction

endpackage

@@ rtl/bba_in_if.sv @@
// ----------------------------------------------------------------------------
// bba_in_if
// Request channel: operation, request size and offset.
// ----------------------------------------------------------------------------
interface bba_in_if;
  import bba_pkg::*;
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [REQ_W-1:0]  request_size;
  logic [OFF_W-1:0]  offset;

  modport source (output valid, output func, output request_size, output offset,
                  input ready);
  modport sink   (input valid, input func, input request_size, input offset,
                  output ready);
endinterface

@@ rtl/bba_out_if.sv @@
// ----------------------------------------------------------------------------
// bba_out_if
// Result channel: status, block offset and block size.
// ----------------------------------------------------------------------------
interface bba_out_if;
  import bba_pkg::*;
  logic             valid;
  logic             ready;
  logic [ST_W-1:0]  status;
  logic [OFF_W-1:0] block_offset;
  logic [BSZ_W-1:0] block_size;

  modport source (output valid, output status, output block_offset,
                  output block_size, input ready);
  modport sink   (input valid, input status, input block_offset,
                  input block_size, output ready);
endinterface

@@ rtl/bba_datapath.sv @@
// ----------------------------------------------------------------------------
// bba_datapath
// Tree memory of longest free blocks, walk registers and result registers.
// ----------------------------------------------------------------------------
module bba_datapath #(
  parameter int POOL_UNITS = 1024
) (
  input  logic                       clk,
  input  bba_pkg::dp_op_t            op,
  input  logic [bba_pkg::FUNC_W-1:0] in_func,
  input  logic [bba_pkg::REQ_W-1:0]  in_request_size,
  input  logic [bba_pkg::OFF_W-1:0]  in_offset,
  output bba_pkg::dp_status_t        stat,
  output logic [bba_pkg::ST_W-1:0]   out_status,
  output logic [bba_pkg::OFF_W-1:0]  out_block_offset,
  output logic [bba_pkg::BSZ_W-1:0]  out_block_size
);
  import bba_pkg::*;

  localparam int LEVELS = $clog2(POOL_UNITS);
  localparam int NW     = LEVELS + 1;
  localparam int VW     = LEVELS + 1;
  localparam int NODES  = 2 * POOL_UNITS - 1;
  localparam int CW     = (VW > WANT_W) ? VW : WANT_W;

  logic [VW-1:0]     mem_r [NODES];
  logic [VW-1:0]     rd_a_r, rd_b_r;
  logic [NW-1:0]     idx_r, idx_nxt;
  logic [VW-1:0]     sz_r, sz_nxt;
  logic [LEVELS-1:0] acc_r, acc_nxt;
  logic [WANT_W-1:0] want_r, want_nxt;
  logic [FUNC_W-1:0] func_r, func_nxt;
  logic [ST_W-1:0]   res_st_r, res_st_nxt;
  logic [LEVELS-1:0] res_off_r, res_off_nxt;
  logic [VW-1:0]     res_sz_r, res_sz_nxt;
  logic [ST_W-1:0]   out_st_r;
  logic [OFF_W-1:0]  out_off_r;
  logic [BSZ_W-1:0]  out_sz_r;

  logic [NW-1:0]     addr_a, addr_b, waddr;
  logic              we;
  logic [VW-1:0]     wdata;

  logic [31:0]       leaf_w;
  logic [NW-1:0]     leaf, left, parent, pl, nidx, n1;
  logic              go_left, merge, off_bad;
  logic [VW-1:0]     nsz, mx;
  logic [VW:0]       sum;

  // Tree navigation
  assign leaf_w  = 32'(in_offset) + 32'(POOL_UNITS) - 32'd1;
  assign leaf    = leaf_w[NW-1:0];
  assign off_bad = 32'(in_offset) >= 32'(POOL_UNITS);
  assign left    = {idx_r[NW-2:0], 1'b1};
  assign parent  = (idx_r - NW'(1)) >> 1;
  assign pl      = {parent[NW-2:0], 1'b1};
  assign go_left = CW'(rd_a_r) >= CW'(want_r);
  assign nidx    = go_left ? left : left + NW'(1);
  assign nsz     = sz_r >> 1;
  assign n1      = idx_r + NW'(1);
  assign sum     = {1'b0, rd_a_r} + {1'b0, rd_b_r};
  assign mx      = (rd_a_r > rd_b_r) ? rd_a_r : rd_b_r;
  assign merge   = (func_r == FUNC_FREE) && (sum == {1'b0, sz_r});

  // Status to the controller
  assign stat.clr_last     = idx_r == NW'(NODES - 1);
  assign stat.off_bad      = off_bad;
  assign stat.root_short   = CW'(rd_a_r) < CW'(want_r);
  assign stat.sz_gt_want   = CW'(sz_r) > CW'(want_r);
  assign stat.half_gt_want = CW'(nsz) > CW'(want_r);
  assign stat.rd_zero      = rd_a_r == '0;
  assign stat.at_root      = idx_r == '0;
  assign stat.func         = func_r;
  assign stat.new_func     = in_func;

  // Decode the command
  always_comb begin
    idx_nxt     = idx_r;
    sz_nxt      = sz_r;
    acc_nxt     = acc_r;
    want_nxt    = want_r;
    func_nxt    = func_r;
    res_st_nxt  = res_st_r;
    res_off_nxt = res_off_r;
    res_sz_nxt  = res_sz_r;
    addr_a      = idx_r;
    addr_b      = idx_r;
    we          = 1'b0;
    waddr       = idx_r;
    wdata       = sz_r;
    case (op)
      OP_CLR_INIT: begin
        idx_nxt = '0;
        sz_nxt  = VW'(POOL_UNITS);
      end
      OP_CLR: begin
        we      = 1'b1;
        idx_nxt = n1;
        if (((n1 + NW'(1)) & n1) == '0) sz_nxt = nsz;
      end
      OP_LOAD: begin
        func_nxt    = in_func;
        want_nxt    = round_pow2(in_request_size);
        acc_nxt     = '0;
        res_off_nxt = '0;
        res_sz_nxt  = '0;
        res_st_nxt  = ST_OK;
        if (in_func == FUNC_ALLOC) begin
          idx_nxt = '0;
          sz_nxt  = VW'(POOL_UNITS);
          addr_a  = '0;
        end else begin
          idx_nxt = leaf;
          sz_nxt  = VW'(1);
          addr_a  = leaf;
          if ((in_func == FUNC_FREE || in_func == FUNC_QUERY) && off_bad)
            res_st_nxt = ST_NOTALLOC;
        end
      end
      OP_ROOT: begin
        addr_a = left;
      end
      OP_DESC: begin
        idx_nxt = nidx;
        sz_nxt  = nsz;
        if (!go_left) acc_nxt = acc_r + LEVELS'(nsz);
        addr_a  = {nidx[NW-2:0], 1'b1};
      end
      OP_MARK: begin
        we          = 1'b1;
        wdata       = '0;
        res_sz_nxt  = sz_r;
        res_off_nxt = acc_r;
      end
      OP_CLIMB_UP: begin
        idx_nxt = parent;
        sz_nxt  = sz_r << 1;
        addr_a  = parent;
      end
      OP_FOUND: begin
        res_sz_nxt = sz_r;
        if (func_r == FUNC_FREE) we = 1'b1;
      end
      OP_UP_RD: begin
        idx_nxt = parent;
        sz_nxt  = sz_r << 1;
        addr_a  = pl;
        addr_b  = pl + NW'(1);
      end
      OP_UP_WR: begin
        we    = 1'b1;
        wdata = merge ? sz_r : mx;
      end
      OP_FAIL_SPACE: res_st_nxt = ST_NOSPACE;
      OP_FAIL_ALLOC: res_st_nxt = ST_NOTALLOC;
      default: ;
    endcase
  end

  // Tree memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    rd_a_r <= mem_r[addr_a];
    rd_b_r <= mem_r[addr_b];
  end

  // Walk and result registers
  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    sz_r      <= sz_nxt;
    acc_r     <= acc_nxt;
    want_r    <= want_nxt;
    func_r    <= func_nxt;
    res_st_r  <= res_st_nxt;
    res_off_r <= res_off_nxt;
    res_sz_r  <= res_sz_nxt;
    if (op == OP_PUBLISH) begin
      out_st_r  <= res_st_r;
      out_off_r <= OFF_W'(res_off_r);
      out_sz_r  <= BSZ_W'(res_sz_r);
    end
  end

  assign out_status       = out_st_r;
  assign out_block_offset = out_off_r;
  assign out_block_size   = out_sz_r;

endmodule

@@ rtl/bba_ctrl.sv @@
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer for clearing, descent, climb and ancestor update.
// ----------------------------------------------------------------------------
module bba_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                out_ready,
  output logic                out_valid,
  input  bba_pkg::dp_status_t stat,
  output bba_pkg::dp_op_t     op
);
  import bba_pkg::*;

  typedef enum logic [9:0] {
    S_CLR_INIT = 10'b0000000001,
    S_CLEAR    = 10'b0000000010,
    S_IDLE     = 10'b0000000100,
    S_ROOT     = 10'b0000001000,
    S_DESC     = 10'b0000010000,
    S_MARK     = 10'b0000100000,
    S_CLIMB    = 10'b0001000000,
    S_UP_RD    = 10'b0010000000,
    S_UP_WR    = 10'b0100000000,
    S_DONE     = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Next state and command
  always_comb begin
    state_nxt     = state_r;
    op            = OP_NOP;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_CLR_INIT: begin
        op        = OP_CLR_INIT;
        state_nxt = S_CLEAR;
      end
      S_CLEAR: begin
        op = OP_CLR;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          op = OP_LOAD;
          if (stat.new_func == FUNC_ALLOC) state_nxt = S_ROOT;
          else if ((stat.new_func == FUNC_FREE || stat.new_func == FUNC_QUERY)
                   && !stat.off_bad) state_nxt = S_CLIMB;
          else state_nxt = S_DONE;
        end
      end
      S_ROOT: begin
        if (stat.root_short) begin
          op        = OP_FAIL_SPACE;
          state_nxt = S_DONE;
        end else if (stat.sz_gt_want) begin
          op        = OP_ROOT;
          state_nxt = S_DESC;
        end else begin
          state_nxt = S_MARK;
        end
      end
      S_DESC: begin
        op = OP_DESC;
        if (!stat.half_gt_want) state_nxt = S_MARK;
      end
      S_MARK: begin
        op        = OP_MARK;
        state_nxt = stat.at_root ? S_DONE : S_UP_RD;
      end
      S_CLIMB: begin
        if (stat.rd_zero) begin
          op = OP_FOUND;
          if (stat.func == FUNC_QUERY || stat.at_root) state_nxt = S_DONE;
          else state_nxt = S_UP_RD;
        end else if (stat.at_root) begin
          op        = OP_FAIL_ALLOC;
          state_nxt = S_DONE;
        end else begin
          op = OP_CLIMB_UP;
        end
      end
      S_UP_RD: begin
        op        = OP_UP_RD;
        state_nxt = S_UP_WR;
      end
      S_UP_WR: begin
        op        = OP_UP_WR;
        state_nxt = stat.at_root ? S_DONE : S_UP_RD;
      end
      S_DONE: begin
        // Hand the result over once the output register is free
        if (!out_valid_r || out_ready) begin
          op            = OP_PUBLISH;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_CLR_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ rtl/buddy_block_allocator.sv @@
// ----------------------------------------------------------------------------
// buddy_block_allocator
// Buddy allocator over a binary tree of longest free blocks.
// ----------------------------------------------------------------------------
// Operation: allocate descends from the root, free and query climb from the leaf,
//   walking one node per cycle; allocate and free then update the ancestors
//   by a read-then-write pass on the tree memory.
// Throughput: one operation at a time; next request taken after the result
//   is registered.
// Reset: clears control, then sweeps the tree memory.
module buddy_block_allocator #(
  parameter int POOL_UNITS = 1024
) (
  input  logic      clk,
  input  logic      rst_n,
  bba_in_if.sink    in_ch,
  bba_out_if.source out_ch
);
  import bba_pkg::*;

  dp_op_t     op;
  dp_status_t stat;

  bba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .stat      (stat),
    .op        (op)
  );

  bba_datapath #(.POOL_UNITS(POOL_UNITS)) u_datapath (
    .clk              (clk),
    .op               (op),
    .in_func          (in_ch.func),
    .in_request_size  (in_ch.request_size),
    .in_offset        (in_ch.offset),
    .stat             (stat),
    .out_status       (out_ch.status),
    .out_block_offset (out_ch.block_offset),
    .out_block_size   (out_ch.block_size)
  );

endmodule

@@ dv/tb_buddy_block_allocator.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_buddy_block_allocator
// Self-checking bench for the buddy block allocator: a tree model predicts
// every response, results are compared field by field in order.
// ----------------------------------------------------------------------------
module tb_buddy_block_allocator;
  import bba_pkg::*;

  localparam int POOL     = 1024;
  localparam int NODES    = 2 * POOL - 1;
  localparam int WDOG_MAX = 20000;
  localparam logic [FUNC_W-1:0] FUNC_RSVD = 2'd3;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [OFF_W-1:0] block_offset;
    logic [BSZ_W-1:0] block_size;
  } alloc_resp_t;

  logic clk;
  logic rst_n;

  bba_in_if  in_ch ();
  bba_out_if out_ch ();

  buddy_block_allocator #(.POOL_UNITS(POOL)) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Predictor state: longest free run per tree node
  int unsigned  longest_free[NODES];
  alloc_resp_t  resp_queue[$];
  int unsigned  live_offsets[$];
  int           mismatch_count;
  int           in_idle_pct;
  int           out_stall_pct;
  bit           hold_off;
  int           quiet_cycles;

  // Clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int unsigned pow2_ceil(int unsigned v);
    int unsigned p;
    p = 1;
    while (p < v) p = p << 1;
    return p;
  endfunction

  function automatic void tree_reset();
    int unsigned sz;
    sz = 2 * POOL;
    for (int i = 0; i < NODES; i++) begin
      if (((i + 1) & i) == 0) sz = sz >> 1;
      longest_free[i] = sz;
    end
  endfunction

  // Climb to the first zero node covering off; 0 size means not allocated
  function automatic void locate_block(int unsigned off, output int unsigned node,
                                       output int unsigned sz);
    int unsigned idx;
    node = 0;
    sz   = 0;
    if (off >= POOL) return;
    idx = off + POOL - 1;
    sz  = 1;
    while (longest_free[idx] != 0) begin
      if (idx == 0) begin
        sz = 0;
        return;
      end
      idx = (idx - 1) >> 1;
      sz  = sz << 1;
    end
    node = idx;
  endfunction

  // Apply one operation to the tree and return the expected response
  function automatic alloc_resp_t predict_alloc(logic [FUNC_W-1:0] fn,
                                                logic [REQ_W-1:0] req,
                                                logic [OFF_W-1:0] off);
    alloc_resp_t r;
    int unsigned want, idx, sz, lft, rgt;
    r = '0;
    case (fn)
      FUNC_ALLOC: begin
        want = (req == 0) ? 1 : pow2_ceil(req);
        if (longest_free[0] < want) begin
          r.status = ST_NOSPACE;
        end else begin
          idx = 0;
          sz  = POOL;
          while (sz > want) begin
            lft = 2 * idx + 1;
            idx = (longest_free[lft] >= want) ? lft : lft + 1;
            sz  = sz >> 1;
          end
          longest_free[idx] = 0;
          r.status       = ST_OK;
          r.block_offset = OFF_W'((idx + 1) * sz - POOL);
          r.block_size   = BSZ_W'(sz);
          while (idx != 0) begin
            idx = (idx - 1) >> 1;
            lft = longest_free[2 * idx + 1];
            rgt = longest_free[2 * idx + 2];
            longest_free[idx] = (lft > rgt) ? lft : rgt;
          end
        end
      end
      FUNC_FREE: begin
        locate_block(off, idx, sz);
        if (sz == 0) begin
          r.status = ST_NOTALLOC;
        end else begin
          r.block_size = BSZ_W'(sz);
          longest_free[idx] = sz;
          while (idx != 0) begin
            idx = (idx - 1) >> 1;
            sz  = sz << 1;
            lft = longest_free[2 * idx + 1];
            rgt = longest_free[2 * idx + 2];
            longest_free[idx] = (lft + rgt == sz) ? sz : ((lft > rgt) ? lft : rgt);
          end
        end
      end
      FUNC_QUERY: begin
        locate_block(off, idx, sz);
        if (sz == 0) r.status = ST_NOTALLOC;
        else         r.block_size = BSZ_W'(sz);
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int exp_val);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, exp_val, $time);
    mismatch_count++;
  endtask

  // Offer one request and hold it until the transfer
  task automatic send_op(logic [FUNC_W-1:0] fn, logic [REQ_W-1:0] req,
                         logic [OFF_W-1:0] off);
    alloc_resp_t r;
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.func         <= fn;
    in_ch.request_size <= req;
    in_ch.offset       <= off;
    do @(posedge clk); while (!in_ch.ready);
    r = predict_alloc(fn, req, off);
    resp_queue.push_back(r);
    if (fn == FUNC_ALLOC && r.status == ST_OK) live_offsets.push_back(r.block_offset);
  endtask

  // Drop the request and wait until every expected result has come
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (resp_queue.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Pick an offset at or just past the start of a live block, or anything at all
  function automatic logic [OFF_W-1:0] pick_offset();
    int k;
    if (live_offsets.size() != 0 && $urandom_range(99) < 75) begin
      k = $urandom_range(live_offsets.size() - 1);
      return OFF_W'(live_offsets[k] + ($urandom_range(99) < 70 ? 0 : $urandom_range(3)));
    end
    return OFF_W'($urandom);
  endfunction

  task automatic random_op();
    int sel;
    logic [REQ_W-1:0] req;
    logic [OFF_W-1:0] off;
    int k;
    sel = $urandom_range(99);
    case ($urandom_range(9))
      0:       req = REQ_W'($urandom);
      1, 2:    req = REQ_W'($urandom_range(1024, 0));
      default: req = REQ_W'($urandom_range(16, 0));
    endcase
    if (sel < 45) begin
      send_op(FUNC_ALLOC, req, OFF_W'($urandom));
    end else if (sel < 80) begin
      off = pick_offset();
      if (live_offsets.size() != 0 && $urandom_range(1)) begin
        k   = $urandom_range(live_offsets.size() - 1);
        off = OFF_W'(live_offsets[k]);
        live_offsets.delete(k);
      end
      send_op(FUNC_FREE, REQ_W'($urandom), off);
    end else if (sel < 97) begin
      send_op(FUNC_QUERY, REQ_W'($urandom), pick_offset());
    end else begin
      send_op(FUNC_RSVD, REQ_W'($urandom), OFF_W'($urandom));
    end
  endtask

  // Result side: stall at random, compare each transfer
  always @(posedge clk) begin
    alloc_resp_t e;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (resp_queue.size() == 0) begin
          report_mismatch("unexpected result", out_ch.status, -1);
        end else begin
          e = resp_queue.pop_front();
          if (out_ch.status !== e.status)
            report_mismatch("status", out_ch.status, e.status);
          if (out_ch.block_offset !== e.block_offset)
            report_mismatch("block_offset", out_ch.block_offset, e.block_offset);
          if (out_ch.block_size !== e.block_size)
            report_mismatch("block_size", out_ch.block_size, e.block_size);
        end
      end
      out_ch.ready <= !hold_off && ($urandom_range(99) >= out_stall_pct);
    end
  end

  // Watchdog on transfers
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WDOG_MAX) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Boundaries and special cases
  task automatic test_directed();
    send_op(FUNC_QUERY, '0, '0);
    send_op(FUNC_FREE, '0, 10'd1023);
    send_op(FUNC_ALLOC, 11'd2047, '0);
    send_op(FUNC_ALLOC, 11'd1025, '0);
    send_op(FUNC_ALLOC, 11'd1024, '0);
    send_op(FUNC_ALLOC, 11'd1, '0);
    send_op(FUNC_QUERY, '0, 10'd777);
    send_op(FUNC_FREE, '0, 10'd513);
    send_op(FUNC_ALLOC, '0, 10'h3ff);
    send_op(FUNC_ALLOC, 11'd3, '0);
    send_op(FUNC_ALLOC, 11'd513, '0);
    send_op(FUNC_QUERY, '0, 10'd2);
    send_op(FUNC_FREE, '0, 10'd3);
    send_op(FUNC_RSVD, 11'h7ff, 10'h3ff);
    send_op(FUNC_FREE, '0, '0);
    send_op(FUNC_FREE, '0, '0);
    send_op(FUNC_ALLOC, 11'd1024, '0);
    send_op(FUNC_ALLOC, '0, '0);
    send_op(FUNC_FREE, 11'h7ff, 10'h200);
    send_op(FUNC_QUERY, 11'h7ff, 10'h155);
    send_op(FUNC_QUERY, '0, 10'h2aa);
    wait_drained();
    live_offsets.delete();
  endtask

  task automatic test_random(int n, int idle_pct, int stall_pct);
    in_idle_pct   = idle_pct;
    out_stall_pct = stall_pct;
    repeat (n) random_op();
    in_idle_pct   = 0;
    out_stall_pct = 0;
  endtask

  // Receiver holds off while requests keep coming, so the block backs up
  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      repeat (12) random_op();
    join
    wait_drained();
  endtask

  initial begin
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.func         = '0;
    in_ch.request_size = '0;
    in_ch.offset       = '0;
    out_ch.ready       = 1'b0;
    hold_off           = 1'b0;
    quiet_cycles       = 0;
    mismatch_count     = 0;
    in_idle_pct        = 0;
    out_stall_pct      = 0;
    tree_reset();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(350, 0, 0);
    test_random(350, 52, 0);
    test_backpressure();
    test_random(350, 0, 52);
    wait_drained();
    test_random(350, 24, 24);
    wait_drained();

    if (mismatch_count == 0 && resp_queue.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
